@@ sv/lrcc_pkg.sv @@
// shared types and constants of the left/right consistency check
`timescale 1ns / 1ps
package lrcc_pkg;

  localparam int COST_W      = 16;
  localparam int COLUMN_W    = 12;
  localparam int DISP_W      = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int ROW_WIDTH_W = 13;
  localparam int DCOUNT_W    = 7;
  localparam int MAXDIFF_W   = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_WIDTH       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DISPARITY_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DIFFERENCE  = 2'd2;

  localparam int ROW_WIDTH_RESET       = 640;
  localparam int DISPARITY_COUNT_RESET = 20;
  localparam int MAX_DIFFERENCE_RESET  = 1;

  localparam logic signed [DISP_W-1:0] DISP_FAIL = -7'sd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_READ,
    ST_LOAD,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic load;
    logic next;
  } cmd_t;

  typedef struct packed {
    logic emit_any;
    logic emit_done;
  } status_t;

endpackage

@@ sv/left_right_consistency_check.sv @@
// top level of the stereo left/right consistency check
// a cost item is accepted, then the right-minimum memory is read-modified-written
// an item that finishes a column gives its first result after the update, read and load states
// each further result of a row-end flush goes through memory read, load and send; send holds while result_stall is high
// reset: row_width 640, disparity_count 20, max_difference 1, row position zero
// slot memories are not cleared; every slot is written in a row before it is read
`timescale 1ns / 1ps
module left_right_consistency_check #(
  parameter int MAX_DISPARITY = 64,
  parameter int MAX_WIDTH     = 4096,
  parameter int COST_BITS     = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cost_valid,
  output logic                                 cost_stall,
  input  logic [lrcc_pkg::COST_W-1:0]          cost,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic [lrcc_pkg::COLUMN_W-1:0]        column,
  output logic signed [lrcc_pkg::DISP_W-1:0]   disparity,
  output logic                                 run_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lrcc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lrcc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import lrcc_pkg::*;

  cmd_t    cmd;
  status_t status;

  lrcc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cost_valid  (cost_valid),
    .cost_stall  (cost_stall),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .cfg_ready   (cfg_ready),
    .cmd         (cmd),
    .status      (status)
  );

  lrcc_datapath #(
    .MAX_DISPARITY(MAX_DISPARITY),
    .MAX_WIDTH    (MAX_WIDTH),
    .COST_BITS    (COST_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cost     (cost),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .column   (column),
    .disparity(disparity),
    .run_last (run_last)
  );

endmodule

@@ sv/lrcc_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps
module lrcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/lrcc_ctrl.sv @@
// controller state machine of the left/right consistency check
`timescale 1ns / 1ps
module lrcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cost_valid,
  output logic              cost_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              cfg_ready,
  output lrcc_pkg::cmd_t    cmd,
  input  lrcc_pkg::status_t status
);
  import lrcc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cost_stall   = 1'b1;
    result_valid = 1'b0;
    cfg_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cost_stall = 1'b0;
        // a waiting cost item goes first, so a register write never meets one
        cfg_ready  = !cost_valid;
        if (cost_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.emit_any ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        result_valid = 1'b1;
        if (!result_stall) begin
          if (status.emit_done) begin
            state_next = ST_IDLE;
          end else begin
            cmd.next   = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/lrcc_datapath.sv @@
// datapath: row counters, running minima, slot memories and result register
`timescale 1ns / 1ps
module lrcc_datapath #(
  parameter int MAX_DISPARITY = 64,
  parameter int MAX_WIDTH     = 4096,
  parameter int COST_BITS     = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [lrcc_pkg::COST_W-1:0]             cost,
  input  logic                                    cfg_we,
  input  logic [lrcc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [lrcc_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  lrcc_pkg::cmd_t                          cmd,
  output lrcc_pkg::status_t                       status,
  output logic [lrcc_pkg::COLUMN_W-1:0]           column,
  output logic signed [lrcc_pkg::DISP_W-1:0]      disparity,
  output logic                                    run_last
);
  import lrcc_pkg::*;

  localparam int CW     = (COST_BITS < COST_W) ? COST_BITS : COST_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int D_W    = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
  localparam int DC_W   = $clog2(MAX_DISPARITY + 1);
  localparam int XW     = ((COL_W > DC_W) ? COL_W : DC_W) + 1;
  localparam int SLOT_W = D_W;
  localparam int DEPTH  = 2 ** SLOT_W;
  localparam int RW     = CW + D_W;

  // configuration, held clamped
  logic [W_W-1:0]       w_used;
  logic [DC_W-1:0]      dc_used;
  logic [MAXDIFF_W-1:0] max_diff;

  logic [COL_W-1:0] col_count;
  logic [D_W-1:0]   disp_index;
  logic [CW-1:0]    left_cost;
  logic [D_W-1:0]   left_index;

  logic [CW-1:0]    cost_w;
  logic [COL_W-1:0] j_w;
  logic [D_W-1:0]   d_w;
  logic [COL_W-1:0] ecol;
  logic [COL_W-1:0] eend;

  logic [XW-1:0]    wx, dcx, jx_in, dx_in, jx, dx, j1x, rmw_x, emit_x, col_x;
  logic [XW-1:0]    ecol_x, wr_x;
  logic [COL_W-1:0] j_in;
  logic [D_W-1:0]   d_in;
  logic [CW-1:0]    cost_in;
  logic             last_d, row_end, in_range;

  logic [SLOT_W-1:0] raddr;
  logic [RW-1:0]     right_rdata;
  logic [D_W-1:0]    pend_rdata;
  logic              right_we;
  logic [CW-1:0]     right_cost;
  logic [D_W-1:0]    right_index;

  logic [DISP_W-1:0] l7, r7, diff7;

  assign wx      = XW'(w_used);
  assign dcx     = XW'(dc_used);
  assign cost_in = cost[CW-1:0];
  assign col_x   = XW'(col_count);
  assign j_in    = (col_x >= wx) ? '0 : col_count;
  assign d_in    = (XW'(disp_index) >= dcx) ? '0 : disp_index;
  assign jx_in   = XW'(j_in);
  assign dx_in   = XW'(d_in);
  assign rmw_x   = jx_in - dx_in;

  assign jx       = XW'(j_w);
  assign dx       = XW'(d_w);
  assign j1x      = jx + XW'(1);
  assign emit_x   = j1x - dcx;
  assign last_d   = (dx + XW'(1)) == dcx;
  assign row_end  = j1x == wx;
  assign in_range = dx <= jx;
  assign wr_x     = jx - dx;
  assign ecol_x   = XW'(ecol);

  assign status.emit_any  = last_d && ((j1x >= dcx) || row_end);
  assign status.emit_done = ecol == eend;

  assign raddr = cmd.accept ? rmw_x[SLOT_W-1:0] : ecol_x[SLOT_W-1:0];

  assign right_cost  = right_rdata[RW-1:D_W];
  assign right_index = right_rdata[D_W-1:0];
  assign right_we    = cmd.update && ((d_w == '0) || (in_range && cost_w < right_cost));

  lrcc_ram #(
    .WIDTH(RW),
    .DEPTH(DEPTH)
  ) u_right_ram (
    .clk  (clk),
    .we   (right_we),
    .waddr(wr_x[SLOT_W-1:0]),
    .wdata({cost_w, d_w}),
    .raddr(raddr),
    .rdata(right_rdata)
  );

  lrcc_ram #(
    .WIDTH(D_W),
    .DEPTH(DEPTH)
  ) u_pend_ram (
    .clk  (clk),
    .we   (cmd.update && last_d),
    .waddr(jx[SLOT_W-1:0]),
    .wdata(left_index),
    .raddr(raddr),
    .rdata(pend_rdata)
  );

  // configuration and row position
  always_ff @(posedge clk) begin
    if (rst) begin
      w_used     <= W_W'(ROW_WIDTH_RESET);
      dc_used    <= DC_W'(DISPARITY_COUNT_RESET);
      max_diff   <= MAXDIFF_W'(MAX_DIFFERENCE_RESET);
      col_count  <= '0;
      disp_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: begin
          if (cfg_data[ROW_WIDTH_W-1:0] == '0) begin
            w_used <= W_W'(1);
          end else if (int'(cfg_data[ROW_WIDTH_W-1:0]) > MAX_WIDTH) begin
            w_used <= W_W'(MAX_WIDTH);
          end else begin
            w_used <= W_W'(cfg_data[ROW_WIDTH_W-1:0]);
          end
        end
        REG_DISPARITY_COUNT: begin
          if (cfg_data[DCOUNT_W-1:0] == '0) begin
            dc_used <= DC_W'(1);
          end else if (int'(cfg_data[DCOUNT_W-1:0]) > MAX_DISPARITY) begin
            dc_used <= DC_W'(MAX_DISPARITY);
          end else begin
            dc_used <= DC_W'(cfg_data[DCOUNT_W-1:0]);
          end
        end
        REG_MAX_DIFFERENCE: begin
          max_diff <= cfg_data[MAXDIFF_W-1:0];
        end
        default: begin
        end
      endcase
      if (cfg_index == REG_ROW_WIDTH || cfg_index == REG_DISPARITY_COUNT ||
          cfg_index == REG_MAX_DIFFERENCE) begin
        col_count  <= '0;
        disp_index <= '0;
      end
    end else if (cmd.update) begin
      if (last_d) begin
        disp_index <= '0;
        col_count  <= row_end ? '0 : COL_W'(j1x);
      end else begin
        disp_index <= D_W'(dx + XW'(1));
        col_count  <= j_w;
      end
    end
  end

  // item capture, left minimum, emit range and result register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cost_w <= cost_in;
      j_w    <= j_in;
      d_w    <= d_in;
      if (d_in == '0) begin
        left_cost  <= cost_in;
        left_index <= '0;
      end else if (dx_in <= jx_in && cost_in < left_cost) begin
        left_cost  <= cost_in;
        left_index <= d_in;
      end
    end
    if (cmd.update) begin
      ecol <= (j1x >= dcx) ? COL_W'(emit_x) : '0;
      eend <= row_end ? COL_W'(wx - XW'(1)) : COL_W'(emit_x);
    end else if (cmd.next) begin
      ecol <= ecol + COL_W'(1);
    end
    if (cmd.load) begin
      column    <= COLUMN_W'(ecol);
      disparity <= (diff7 > DISP_W'(max_diff)) ? DISP_FAIL : signed'(l7);
      run_last  <= ecol == eend;
    end
  end

  assign l7    = DISP_W'(pend_rdata);
  assign r7    = DISP_W'(right_index);
  assign diff7 = (l7 > r7) ? (l7 - r7) : (r7 - l7);

endmodule
